// ===== rtl/csc_pkg.sv =====
// shared types and fixed-point constants for the colour space converter
package csc_pkg;

  // fraction bits of every coefficient and weighted sum
  localparam int COEF_FRAC_BITS = 16;
  // sum width: fraction bits, ten integer bits and the sign
  localparam int SUM_W = COEF_FRAC_BITS + 11;
  // byte address width of the register port
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;

  // register indexes, taken from paddr bit 2
  localparam logic REG_SRC = 1'b0;
  localparam logic REG_DST = 1'b1;

  typedef enum logic [1:0] {
    SPACE_GREY = 2'd0,
    SPACE_RGB  = 2'd1,
    SPACE_RGBA = 2'd2,
    SPACE_YUV  = 2'd3
  } space_t;

  typedef struct packed {
    space_t src;
    space_t dst;
  } cfg_t;

  // chan_a in the lowest byte
  typedef struct packed {
    logic [7:0] chan_alpha;
    logic [7:0] chan_c;
    logic [7:0] chan_b;
    logic [7:0] chan_a;
  } pix_t;

  // out_a in the lowest byte
  typedef struct packed {
    logic [7:0] out_alpha;
    logic [7:0] out_c;
    logic [7:0] out_b;
    logic [7:0] out_a;
  } res_t;

  // coefficient scaled by 1e7, rounded to nearest at COEF_FRAC_BITS
  function automatic logic signed [SUM_W-1:0] fx(input longint unsigned c7);
    longint unsigned scaled;
    scaled = (c7 * (64'd1 << COEF_FRAC_BITS) + 64'd5000000) / 64'd10000000;
    return SUM_W'(scaled);
  endfunction

  localparam logic signed [SUM_W-1:0] K_YR   = fx(64'd2990000);
  localparam logic signed [SUM_W-1:0] K_YG   = fx(64'd5870000);
  localparam logic signed [SUM_W-1:0] K_YB   = fx(64'd1140000);
  localparam logic signed [SUM_W-1:0] K_UR   = fx(64'd1687000);
  localparam logic signed [SUM_W-1:0] K_UG   = fx(64'd3313000);
  localparam logic signed [SUM_W-1:0] K_HALF = fx(64'd5000000);
  localparam logic signed [SUM_W-1:0] K_VG   = fx(64'd4187000);
  localparam logic signed [SUM_W-1:0] K_VB   = fx(64'd813000);
  localparam logic signed [SUM_W-1:0] K_RU   = fx(64'd9267);
  localparam logic signed [SUM_W-1:0] K_RV   = fx(64'd14016868);
  localparam logic signed [SUM_W-1:0] K_GU   = fx(64'd3436954);
  localparam logic signed [SUM_W-1:0] K_GV   = fx(64'd7141690);
  localparam logic signed [SUM_W-1:0] K_BU   = fx(64'd17721604);
  localparam logic signed [SUM_W-1:0] K_BV   = fx(64'd9902);

  // chroma offset of 128 in fixed point
  localparam logic signed [SUM_W-1:0] K_OFF = SUM_W'(128) <<< COEF_FRAC_BITS;

endpackage

// ===== rtl/csc_apb_regs.sv =====
// register port holding the source and destination colour spaces
module csc_apb_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [csc_pkg::CFG_AW-1:0]  cfg_paddr,
  input  logic [csc_pkg::CFG_DW-1:0]  cfg_pwdata,
  output logic [csc_pkg::CFG_DW-1:0]  cfg_prdata,
  output logic                        cfg_pready,
  output csc_pkg::cfg_t               cfg_o
);

  csc_pkg::space_t src_r, src_nxt;
  csc_pkg::space_t dst_r, dst_nxt;
  logic            wr_en;
  logic            reg_idx;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite;
  assign reg_idx    = cfg_paddr[2];

  // write decode, only the low two data bits are kept
  always_comb begin
    src_nxt = src_r;
    dst_nxt = dst_r;
    if (wr_en) begin
      unique case (reg_idx)
        csc_pkg::REG_SRC: src_nxt = csc_pkg::space_t'(cfg_pwdata[1:0]);
        csc_pkg::REG_DST: dst_nxt = csc_pkg::space_t'(cfg_pwdata[1:0]);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_r <= csc_pkg::SPACE_RGB;
      dst_r <= csc_pkg::SPACE_YUV;
    end else begin
      src_r <= src_nxt;
      dst_r <= dst_nxt;
    end
  end

  // read back
  always_comb begin
    cfg_prdata = '0;
    unique case (reg_idx)
      csc_pkg::REG_SRC: cfg_prdata[1:0] = src_r;
      csc_pkg::REG_DST: cfg_prdata[1:0] = dst_r;
      default: ;
    endcase
  end

  assign cfg_o.src = src_r;
  assign cfg_o.dst = dst_r;

endmodule

// ===== rtl/csc_convert.sv =====
// per-pixel fixed-point conversion between grey, rgb, rgba and yuv
module csc_convert (
  input  csc_pkg::pix_t pix_i,
  input  csc_pkg::cfg_t cfg_i,
  output csc_pkg::res_t res_o
);

  localparam int F = csc_pkg::COEF_FRAC_BITS;
  localparam int W = csc_pkg::SUM_W;

  logic signed [W-1:0] sa, sb, sc, du, dv, yb;
  logic signed [W-1:0] y_sum, u_sum, v_sum, r_sum, g_sum, b_sum;
  logic [7:0]          r, g, b, a, y, u, v;

  // truncate toward zero, then saturate to 0..255
  function automatic logic [7:0] sat8(input logic signed [W-1:0] s);
    logic [7:0] q;
    if (s < 0) begin
      q = 8'd0;
    end else if (s[W-2:F+8] != '0) begin
      q = 8'hff;
    end else begin
      q = s[F+7:F];
    end
    return q;
  endfunction

  assign sa = W'(pix_i.chan_a);
  assign sb = W'(pix_i.chan_b);
  assign sc = W'(pix_i.chan_c);
  assign du = sb - W'(128);
  assign dv = sc - W'(128);
  assign yb = sa <<< F;

  // rgb to yuv weights
  assign y_sum = csc_pkg::K_YR * sa + csc_pkg::K_YG * sb + csc_pkg::K_YB * sc;
  assign u_sum = csc_pkg::K_HALF * sc - csc_pkg::K_UR * sa - csc_pkg::K_UG * sb
               + csc_pkg::K_OFF;
  assign v_sum = csc_pkg::K_HALF * sa - csc_pkg::K_VG * sb - csc_pkg::K_VB * sc
               + csc_pkg::K_OFF;

  // yuv to rgb weights
  assign r_sum = yb - csc_pkg::K_RU * du + csc_pkg::K_RV * dv;
  assign g_sum = yb - csc_pkg::K_GU * du - csc_pkg::K_GV * dv;
  assign b_sum = yb + csc_pkg::K_BU * du + csc_pkg::K_BV * dv;

  // expand the source into the full channel set
  always_comb begin
    r = pix_i.chan_a;
    g = pix_i.chan_b;
    b = pix_i.chan_c;
    y = pix_i.chan_a;
    u = pix_i.chan_b;
    v = pix_i.chan_c;
    a = 8'hff;
    unique case (cfg_i.src)
      csc_pkg::SPACE_GREY: begin
        g = pix_i.chan_a;
        b = pix_i.chan_a;
        u = 8'd128;
        v = 8'd128;
      end
      csc_pkg::SPACE_RGB, csc_pkg::SPACE_RGBA: begin
        y = sat8(y_sum);
        u = sat8(u_sum);
        v = sat8(v_sum);
        a = (cfg_i.src == csc_pkg::SPACE_RGBA) ? pix_i.chan_alpha : 8'd0;
      end
      csc_pkg::SPACE_YUV: begin
        r = sat8(r_sum);
        g = sat8(g_sum);
        b = sat8(b_sum);
      end
      default: ;
    endcase
  end

  // pick the destination channels, unused ones are zero
  always_comb begin
    res_o = '0;
    unique case (cfg_i.dst)
      csc_pkg::SPACE_GREY: res_o.out_a = y;
      csc_pkg::SPACE_RGB: begin
        res_o.out_a = r;
        res_o.out_b = g;
        res_o.out_c = b;
      end
      csc_pkg::SPACE_RGBA: begin
        res_o.out_a     = r;
        res_o.out_b     = g;
        res_o.out_c     = b;
        res_o.out_alpha = a;
      end
      csc_pkg::SPACE_YUV: begin
        res_o.out_a = y;
        res_o.out_b = u;
        res_o.out_c = v;
      end
      default: ;
    endcase
  end

endmodule

// ===== rtl/color_space_converter.sv =====
// top level: input register, conversion logic and output register
//
//  channel  ports            beat contents
//  in       in_t*            one source pixel, 32-bit tdata
//  out      out_t*           one converted pixel, 32-bit tdata
//  cfg      cfg_p*           source_space at 0x0, dest_space at 0x4
//
// one pixel per clock sustained while out_tready is high; each beat passes
// via the input register, then the output register around the converter.
// rst_n is synchronous, clears both valid flags, sets src rgb and dst yuv.
// a stall on out_tready holds the output register; the input register
// keeps taking a beat while it is empty or moving on.
module color_space_converter (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [31:0]                 in_tdata,   // chan_a, chan_b, chan_c, chan_alpha
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [31:0]                 out_tdata,  // out_a, out_b, out_c, out_alpha
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [csc_pkg::CFG_AW-1:0]  cfg_paddr,
  input  logic [csc_pkg::CFG_DW-1:0]  cfg_pwdata,
  output logic [csc_pkg::CFG_DW-1:0]  cfg_prdata,
  output logic                        cfg_pready
);

  csc_pkg::cfg_t cfg;
  csc_pkg::pix_t s1_pix_r;
  logic          s1_v_r;
  csc_pkg::res_t out_pix_r, out_pix_nxt;
  logic          out_v_r;
  logic          s1_adv;

  csc_apb_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg_o       (cfg)
  );

  csc_convert u_conv (
    .pix_i (s1_pix_r),
    .cfg_i (cfg),
    .res_o (out_pix_nxt)
  );

  // stage hand-off
  assign s1_adv    = !out_v_r || out_tready;
  assign in_tready = !s1_v_r || s1_adv;

  // valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (in_tready) begin
        s1_v_r <= in_tvalid;
      end
      if (s1_adv) begin
        out_v_r <= s1_v_r;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_pix_r <= csc_pkg::pix_t'(in_tdata);
    end
    if (s1_adv && s1_v_r) begin
      out_pix_r <= out_pix_nxt;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_pix_r;

`ifndef SYNTH
  // a held input beat blocks the input while the output is stalled
  a_block_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && out_v_r && !out_tready) |-> !in_tready)
    else $error("input accepted while both stages are full and stalled");

  // an accepted beat lands in the input register
  a_accept_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> s1_v_r)
    else $error("accepted beat lost before the input register");

  // a moving input beat reaches the output register
  a_advance_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && s1_adv) |=> out_v_r)
    else $error("beat lost between input and output register");

  // nothing appears at the output without a beat behind it
  a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
    (!s1_v_r && out_v_r && out_tready) |=> !out_v_r)
    else $error("output valid without a source beat");
`endif

endmodule

// ===== bench/tb_top.sv =====
// self-checking bench for the colour space converter: stream, register port and scoreboard
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 400000;

  // pixel scoreboard: converts each accepted pixel and matches converted beats in order
  class conv_checker;
    csc_pkg::space_t src_space;
    csc_pkg::space_t dst_space;
    csc_pkg::res_t   expected_q[$];
    int              errors;

    function new();
      src_space = csc_pkg::SPACE_RGB;
      dst_space = csc_pkg::SPACE_YUV;
      errors = 0;
    endfunction

    // weight given in units of 1e-7, rounded to the nearest fixed-point step
    static function longint weight(longint c7);
      return ((c7 <<< csc_pkg::COEF_FRAC_BITS) + 64'sd5000000) / 64'sd10000000;
    endfunction

    // fixed-point sum to a byte: division truncates toward zero, then saturate
    static function logic [7:0] to_byte(longint s);
      longint q;
      q = s / (longint'(1) <<< csc_pkg::COEF_FRAC_BITS);
      if (q < 0) return 8'd0;
      if (q > 255) return 8'd255;
      return q[7:0];
    endfunction

    function csc_pkg::res_t convert_pixel(csc_pkg::pix_t p);
      longint ca, cb, cc, one, du, dv;
      logic [7:0] r, g, b, a, y, u, v;
      csc_pkg::res_t res;
      ca = longint'(p.chan_a);
      cb = longint'(p.chan_b);
      cc = longint'(p.chan_c);
      one = longint'(1) <<< csc_pkg::COEF_FRAC_BITS;
      // expand the source into every channel
      case (src_space)
        csc_pkg::SPACE_GREY: begin
          r = p.chan_a; g = p.chan_a; b = p.chan_a; y = p.chan_a;
          u = 8'd128; v = 8'd128; a = 8'd255;
        end
        csc_pkg::SPACE_RGB, csc_pkg::SPACE_RGBA: begin
          r = p.chan_a; g = p.chan_b; b = p.chan_c;
          a = (src_space == csc_pkg::SPACE_RGBA) ? p.chan_alpha : 8'd0;
          y = to_byte(weight(2990000) * ca + weight(5870000) * cb + weight(1140000) * cc);
          u = to_byte(-weight(1687000) * ca - weight(3313000) * cb
                      + weight(5000000) * cc + 128 * one);
          v = to_byte(weight(5000000) * ca - weight(4187000) * cb
                      - weight(813000) * cc + 128 * one);
        end
        default: begin
          du = cb - 128;
          dv = cc - 128;
          y = p.chan_a; u = p.chan_b; v = p.chan_c; a = 8'd255;
          r = to_byte(ca * one - weight(9267) * du + weight(14016868) * dv);
          g = to_byte(ca * one - weight(3436954) * du - weight(7141690) * dv);
          b = to_byte(ca * one + weight(17721604) * du + weight(9902) * dv);
        end
      endcase
      // pick the channels the destination carries, the rest stay zero
      res = '0;
      case (dst_space)
        csc_pkg::SPACE_GREY: res.out_a = y;
        csc_pkg::SPACE_RGB: begin
          res.out_a = r; res.out_b = g; res.out_c = b;
        end
        csc_pkg::SPACE_RGBA: begin
          res.out_a = r; res.out_b = g; res.out_c = b; res.out_alpha = a;
        end
        default: begin
          res.out_a = y; res.out_b = u; res.out_c = v;
        end
      endcase
      return res;
    endfunction

    function void note_pixel(csc_pkg::pix_t p);
      expected_q.push_back(convert_pixel(p));
    endfunction

    function void check_pixel(csc_pkg::res_t got);
      csc_pkg::res_t want;
      string field_names[4] = '{"out_a", "out_b", "out_c", "out_alpha"};
      if (expected_q.size() == 0) begin
        $display("%0t: output beat %h with nothing expected", $time, got);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      for (int i = 0; i < 4; i++) begin
        if (got[8*i +: 8] !== want[8*i +: 8]) begin
          $display("%0t: %s expected %h actual %h", $time, field_names[i],
                   want[8*i +: 8], got[8*i +: 8]);
          errors++;
        end
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_tvalid = 1'b0;
  logic                       in_tready;
  logic [31:0]                in_tdata = '0;     // chan_a, chan_b, chan_c, chan_alpha
  logic                       out_tvalid;
  logic                       out_tready = 1'b0;
  logic [31:0]                out_tdata;         // out_a, out_b, out_c, out_alpha
  logic                       cfg_psel = 1'b0;
  logic                       cfg_penable = 1'b0;
  logic                       cfg_pwrite = 1'b0;
  logic [csc_pkg::CFG_AW-1:0] cfg_paddr = '0;
  logic [csc_pkg::CFG_DW-1:0] cfg_pwdata = '0;
  logic [csc_pkg::CFG_DW-1:0] cfg_prdata;
  logic                       cfg_pready;

  conv_checker sb = new();
  bit          idle_en = 1'b0;
  int          long_hold = 0;
  int          rx_gap = 0;
  int          cycles = 0;

  color_space_converter u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #10 clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end
  end

  // output beat monitor
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_pixel(csc_pkg::res_t'(out_tdata));
  end

  // receiver: long hold-off on request, random stall bursts otherwise
  initial forever begin
    @(negedge clk);
    if (long_hold > 0) begin
      out_tready = 1'b0;
      long_hold--;
    end else if (rx_gap > 0) begin
      out_tready = 1'b0;
      rx_gap--;
    end else if (idle_en && $urandom_range(0, 5) == 0) begin
      out_tready = 1'b0;
      rx_gap = $urandom_range(1, 15) - 1;
    end else begin
      out_tready = 1'b1;
    end
  end

  function automatic csc_pkg::pix_t mk(logic [7:0] a, logic [7:0] b, logic [7:0] c,
                                       logic [7:0] al);
    csc_pkg::pix_t p;
    p.chan_a = a; p.chan_b = b; p.chan_c = c; p.chan_alpha = al;
    return p;
  endfunction

  // channel value leaning toward the extremes and the chroma midpoint
  function automatic logic [7:0] rnd_chan();
    case ($urandom_range(0, 7))
      0: return 8'd0;
      1: return 8'd255;
      2: return 8'd128;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // called at a falling edge, returns at the falling edge after the beat
  task automatic send_pixel(csc_pkg::pix_t p);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_tvalid = 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata = p;
    do @(posedge clk); while (!in_tready);
    sb.note_pixel(p);
    @(negedge clk);
  endtask

  task automatic cfg_write(logic reg_idx, csc_pkg::space_t code);
    logic [31:0] junk;
    junk = $urandom();
    cfg_psel = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b1;
    cfg_paddr = {reg_idx, 2'b00};
    cfg_pwdata = {junk[31:2], code};
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (reg_idx == csc_pkg::REG_SRC) sb.src_space = code;
    else sb.dst_space = code;
    @(negedge clk);
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
  endtask

  task automatic cfg_read(logic reg_idx, csc_pkg::space_t code);
    cfg_psel = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = {reg_idx, 2'b00};
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata !== {30'd0, code}) begin
      $display("%0t: register at %h expected %h actual %h", $time, cfg_paddr,
               {30'd0, code}, cfg_prdata);
      sb.errors++;
    end
    @(negedge clk);
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
  endtask

  // drop valid and let the pipeline empty
  task automatic wait_drained();
    in_tvalid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_spaces(csc_pkg::space_t src, csc_pkg::space_t dst);
    wait_drained();
    cfg_write(csc_pkg::REG_SRC, src);
    cfg_write(csc_pkg::REG_DST, dst);
    cfg_read(csc_pkg::REG_SRC, src);
    cfg_read(csc_pkg::REG_DST, dst);
  endtask

  initial begin
    repeat (11) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);
    cfg_read(csc_pkg::REG_SRC, csc_pkg::SPACE_RGB);
    cfg_read(csc_pkg::REG_DST, csc_pkg::SPACE_YUV);
    idle_en = 1'b1;

    // rgb to yuv under the reset settings: corners and primaries
    send_pixel(mk(8'd0, 8'd0, 8'd0, 8'd0));
    send_pixel(mk(8'd255, 8'd255, 8'd255, 8'd255));
    send_pixel(mk(8'd255, 8'd0, 8'd0, 8'd17));
    send_pixel(mk(8'd0, 8'd255, 8'd0, 8'd0));
    send_pixel(mk(8'd0, 8'd0, 8'd255, 8'd0));
    send_pixel(mk(8'd255, 8'd255, 8'd0, 8'd99));

    // yuv to rgba: saturation at both ends, neutral grey
    set_spaces(csc_pkg::SPACE_YUV, csc_pkg::SPACE_RGBA);
    send_pixel(mk(8'd0, 8'd0, 8'd0, 8'h5a));
    send_pixel(mk(8'd255, 8'd255, 8'd255, 8'h5a));
    send_pixel(mk(8'd255, 8'd0, 8'd0, 8'h00));
    send_pixel(mk(8'd0, 8'd255, 8'd255, 8'hff));
    send_pixel(mk(8'd128, 8'd128, 8'd128, 8'h5a));
    send_pixel(mk(8'd255, 8'd128, 8'd128, 8'h5a));

    // grey source ignores chroma and alpha
    set_spaces(csc_pkg::SPACE_GREY, csc_pkg::SPACE_YUV);
    send_pixel(mk(8'd0, 8'd255, 8'd255, 8'd255));
    send_pixel(mk(8'd255, 8'd0, 8'd0, 8'd0));

    // alpha passes only from rgba to rgba
    set_spaces(csc_pkg::SPACE_RGBA, csc_pkg::SPACE_RGBA);
    send_pixel(mk(8'd10, 8'd20, 8'd30, 8'd0));
    send_pixel(mk(8'd200, 8'd100, 8'd50, 8'd255));

    set_spaces(csc_pkg::SPACE_RGB, csc_pkg::SPACE_GREY);
    send_pixel(mk(8'd255, 8'd255, 8'd255, 8'd255));
    set_spaces(csc_pkg::SPACE_GREY, csc_pkg::SPACE_RGB);
    send_pixel(mk(8'd77, 8'd1, 8'd2, 8'd3));

    // every source and destination pairing with random pixels
    for (int ph = 0; ph < 16; ph++) begin
      set_spaces(csc_pkg::space_t'(ph[3:2]), csc_pkg::space_t'(ph[1:0]));
      for (int i = 0; i < 56; i++) begin
        // long receiver hold-off so the pipeline fills and backs up
        if (ph == 5 && i == 10) long_hold = 120;
        send_pixel(mk(rnd_chan(), rnd_chan(), rnd_chan(), rnd_chan()));
      end
    end

    // closing stretch at full rate
    idle_en = 1'b0;
    set_spaces(csc_pkg::space_t'($urandom_range(0, 3)),
               csc_pkg::space_t'($urandom_range(0, 3)));
    for (int i = 0; i < 40; i++) send_pixel(mk(rnd_chan(), rnd_chan(), rnd_chan(), rnd_chan()));

    wait_drained();
    repeat (10) @(negedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/csc_pkg.sv
rtl/csc_apb_regs.sv
rtl/csc_convert.sv
rtl/color_space_converter.sv
bench/tb_top.sv
